### hw/rtl/lmpc_pkg.sv
// shared types and constants of the light marker position counter
package lmpc_pkg;

  // field widths fixed by the register map and the result format
  localparam int unsigned IntervalW = 16;
  localparam int unsigned MotionW   = 2;
  localparam int unsigned RiseW     = 20;
  localparam int unsigned FallW     = 21;
  localparam int unsigned SpacingW  = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned HeightW   = 24;
  localparam int unsigned EventW    = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 21;

  // slope scale: 1000 ms per second with 8 fraction bits
  localparam int SlopeScale   = 256000;
  // bits of SlopeScale as a signed factor
  localparam int SlopeScaleW  = 19;

  // register reset values
  localparam logic        [RiseW-1:0]    RiseReset    = 20'd256000;
  localparam logic signed [FallW-1:0]    FallReset    = -21'sd235520;
  localparam logic        [SpacingW-1:0] SpacingReset = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRise    = 2'd0,
    CfgFall    = 2'd1,
    CfgSpacing = 2'd2
  } cfg_idx_e;

  typedef enum logic [MotionW-1:0] {
    MotionStill = 2'd0,
    MotionUp    = 2'd1,
    MotionDown  = 2'd2
  } motion_e;

  typedef enum logic [EventW-1:0] {
    EvNone  = 2'd0,
    EvUp    = 2'd1,
    EvDown  = 2'd2,
    EvStill = 2'd3
  } event_e;

endpackage

### hw/rtl/lmpc_if.sv
// valid/ready channel interfaces of the light marker position counter

// sample channel
interface lmpc_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic [SAMPLE_BITS-1:0]            light_sample;
  logic [lmpc_pkg::IntervalW-1:0]    interval_ms;
  logic [lmpc_pkg::MotionW-1:0]      motion;

  modport source (output valid, light_sample, interval_ms, motion, input ready);
  modport sink   (input valid, light_sample, interval_ms, motion, output ready);
endinterface

// result channel
interface lmpc_out_if;
  logic                              valid;
  logic                              ready;
  logic [lmpc_pkg::CountW-1:0]       marker_count;
  logic [lmpc_pkg::HeightW-1:0]      height_m;
  logic                              in_peak;
  logic [lmpc_pkg::EventW-1:0]       marker_event;

  modport source (output valid, marker_count, height_m, in_peak, marker_event, input ready);
  modport sink   (input valid, marker_count, height_m, in_peak, marker_event, output ready);
endinterface

// register write channel
interface lmpc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lmpc_pkg::CfgIdxW-1:0]      index;
  logic [lmpc_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/lmpc_ring.sv
// sample window ring: read-first memory with write pointer and fill tracking
module lmpc_ring #(
  parameter int unsigned WINDOW      = 7,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   interval_nz_i,
  output logic [SAMPLE_BITS-1:0] old_sample_o,
  output logic                   test_o
);

  localparam int unsigned PtrW  = $clog2(WINDOW);
  localparam int unsigned FillW = $clog2(WINDOW + 2);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(WINDOW - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW + 1);

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] old_q;
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic [FillW-1:0]       fill_q, fill_d;
  logic                   test_q, test_d;

  // ring storage: the oldest sample leaves as the new one enters
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      old_q          <= ring_mem[ptr_q];
      ring_mem[ptr_q] <= sample_i;
    end
  end

  // pointer wrap, fill count saturating one past the window
  always_comb begin
    ptr_d  = (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
    fill_d = (fill_q == FillFull) ? fill_q : fill_q + 1'b1;
    // slope test only once the window is full and the previous sum is known
    test_d = (fill_q == FillFull) && interval_nz_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      test_q <= 1'b0;
    end else if (push_i) begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      test_q <= test_d;
    end
  end

  assign old_sample_o = old_q;
  assign test_o       = test_q;

endmodule

### hw/rtl/light_marker_position_counter.sv
// top level of the light marker position counter
//
//   channel   dir  handshake      beat contents
//   sample_i  in   valid/ready    light_sample, interval_ms, motion
//   result_o  out  valid/ready    marker_count, height_m, in_peak, marker_event
//   cfg_i     in   valid/ready    index, data (ready always high)
//
// one sample beat per cycle while results are taken; a result passes the stage 1 to 4 and output registers
// the stages hold the ring read, the slope, span and threshold multiplies and the height multiply
// reset clears control state only; the ring is filled by the first WINDOW beats
// a stalled result holds the pipeline stage by stage; bubbles close up behind it
module light_marker_position_counter #(
  parameter int unsigned WINDOW      = 7,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  lmpc_in_if.sink     sample_i,
  lmpc_out_if.source  result_o,
  lmpc_cfg_if.sink    cfg_i
);

  localparam int unsigned DiffW    = SAMPLE_BITS + 1;
  localparam int unsigned LhsW     = DiffW + lmpc_pkg::SlopeScaleW;
  localparam int unsigned SpanW    = lmpc_pkg::IntervalW + $clog2(WINDOW + 1);
  localparam int unsigned RiseLimW = lmpc_pkg::RiseW + SpanW;
  localparam int unsigned FallLimW = lmpc_pkg::FallW + SpanW;
  localparam int unsigned CmpW     = (LhsW > FallLimW) ? LhsW : FallLimW;

  // configuration registers
  logic        [lmpc_pkg::RiseW-1:0]    rise_q;
  logic signed [lmpc_pkg::FallW-1:0]    fall_q;
  logic        [lmpc_pkg::SpacingW-1:0] spacing_q;
  logic                                 cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q    <= lmpc_pkg::RiseReset;
      fall_q    <= lmpc_pkg::FallReset;
      spacing_q <= lmpc_pkg::SpacingReset;
    end else if (cfg_wr) begin
      case (lmpc_pkg::cfg_idx_e'(cfg_i.index))
        lmpc_pkg::CfgRise:    rise_q    <= cfg_i.data[lmpc_pkg::RiseW-1:0];
        lmpc_pkg::CfgFall:    fall_q    <= $signed(cfg_i.data[lmpc_pkg::FallW-1:0]);
        lmpc_pkg::CfgSpacing: spacing_q <= cfg_i.data[lmpc_pkg::SpacingW-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when it is empty or its successor moves
  logic out_valid_q, s4_valid_q, s3_valid_q, s2_valid_q, s1_valid_q;
  logic out_en, s4_en, s3_en, s2_en, s1_en, push;

  assign out_en         = !out_valid_q || result_o.ready;
  assign s4_en          = !s4_valid_q || out_en;
  assign s3_en          = !s3_valid_q || s4_en;
  assign s2_en          = !s2_valid_q || s3_en;
  assign s1_en          = !s1_valid_q || s2_en;
  assign sample_i.ready = s1_en;
  assign push           = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_q  <= push;
      if (s2_en)  s2_valid_q  <= s1_valid_q;
      if (s3_en)  s3_valid_q  <= s2_valid_q;
      if (s4_en)  s4_valid_q  <= s3_valid_q;
      if (out_en) out_valid_q <= s4_valid_q;
    end
  end

  // stage 1: ring memory read and write
  logic [SAMPLE_BITS-1:0]          ring_old;
  logic                            ring_test;
  logic [SAMPLE_BITS-1:0]          s1_sample_q;
  logic [lmpc_pkg::IntervalW-1:0]  s1_interval_q;
  lmpc_pkg::motion_e               s1_motion_q;

  lmpc_ring #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .sample_i      (sample_i.light_sample),
    .interval_nz_i (sample_i.interval_ms != '0),
    .old_sample_o  (ring_old),
    .test_o        (ring_test)
  );

  always_ff @(posedge clk_i) begin
    if (push) begin
      s1_sample_q   <= sample_i.light_sample;
      s1_interval_q <= sample_i.interval_ms;
      s1_motion_q   <= lmpc_pkg::motion_e'(sample_i.motion);
    end
  end

  // stage 2: sum change scaled to the slope unit, time span of the window
  // the sum change from the previous beat is the new sample less the evicted one
  logic signed [DiffW-1:0] diff;
  logic signed [LhsW-1:0]  s2_lhs_d, s2_lhs_q;
  logic [SpanW-1:0]        s2_span_d, s2_span_q;
  logic                    s2_test_q;
  lmpc_pkg::motion_e       s2_motion_q;

  always_comb begin
    diff      = $signed({1'b0, s1_sample_q}) - $signed({1'b0, ring_old});
    s2_lhs_d  = LhsW'(diff) * LhsW'(lmpc_pkg::SlopeScale);
    s2_span_d = SpanW'(s1_interval_q) * SpanW'(WINDOW);
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_lhs_q    <= s2_lhs_d;
      s2_span_q   <= s2_span_d;
      s2_test_q   <= ring_test;
      s2_motion_q <= s1_motion_q;
    end
  end

  // stage 3: threshold limits over the span
  logic        [RiseLimW-1:0] s3_rise_d, s3_rise_q;
  logic signed [FallLimW-1:0] s3_fall_d, s3_fall_q;
  logic signed [LhsW-1:0]     s3_lhs_q;
  logic                       s3_test_q;
  lmpc_pkg::motion_e          s3_motion_q;

  always_comb begin
    s3_rise_d = RiseLimW'(rise_q) * RiseLimW'(s2_span_q);
    s3_fall_d = FallLimW'(fall_q) * $signed(FallLimW'(s2_span_q));
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_lhs_q    <= s2_lhs_q;
      s3_rise_q   <= s3_rise_d;
      s3_fall_q   <= s3_fall_d;
      s3_test_q   <= s2_test_q;
      s3_motion_q <= s2_motion_q;
    end
  end

  // stage 4: peak tracking and marker count
  logic signed [CmpW-1:0]          lhs_ext, rise_ext, fall_ext;
  logic                            beyond, rising, s3_adv;
  logic                            peak_q, peak_d, edge_q, edge_d;
  logic [lmpc_pkg::CountW-1:0]     count_q, count_d;
  lmpc_pkg::event_e                event_d;
  logic [lmpc_pkg::CountW-1:0]     s4_count_q;
  logic                            s4_peak_q;
  lmpc_pkg::event_e                s4_event_q;

  assign s3_adv = s4_en && s3_valid_q;

  always_comb begin
    lhs_ext  = CmpW'(s3_lhs_q);
    rise_ext = $signed(CmpW'(s3_rise_q));
    fall_ext = CmpW'(s3_fall_q);
    beyond   = (lhs_ext > rise_ext) || (lhs_ext < fall_ext);
    rising   = s3_lhs_q > 0;
  end

  always_comb begin
    peak_d  = peak_q;
    edge_d  = edge_q;
    count_d = count_q;
    event_d = lmpc_pkg::EvNone;
    if (s3_test_q) begin
      if (beyond) begin
        edge_d = rising;
        peak_d = 1'b1;
      end else if (peak_q) begin
        // leaving a peak: a marker passed only after a rising edge
        if (edge_q) begin
          case (s3_motion_q)
            lmpc_pkg::MotionUp: begin
              count_d = count_q + 1'b1;
              event_d = lmpc_pkg::EvUp;
            end
            lmpc_pkg::MotionDown: begin
              count_d = count_q - 1'b1;
              event_d = lmpc_pkg::EvDown;
            end
            default: begin
              event_d = lmpc_pkg::EvStill;
            end
          endcase
        end
        peak_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= 1'b0;
      edge_q  <= 1'b0;
      count_q <= '0;
    end else if (s3_adv) begin
      peak_q  <= peak_d;
      edge_q  <= edge_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_count_q <= count_d;
      s4_peak_q  <= peak_d;
      s4_event_q <= event_d;
    end
  end

  // output register: height from the registered count
  logic [lmpc_pkg::CountW-1:0]  out_count_q;
  logic [lmpc_pkg::HeightW-1:0] out_height_q, out_height_d;
  logic                         out_peak_q;
  lmpc_pkg::event_e             out_event_q;

  assign out_height_d = lmpc_pkg::HeightW'(s4_count_q) * lmpc_pkg::HeightW'(spacing_q);

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_count_q  <= s4_count_q;
      out_height_q <= out_height_d;
      out_peak_q   <= s4_peak_q;
      out_event_q  <= s4_event_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.marker_count = out_count_q;
  assign result_o.height_m     = out_height_q;
  assign result_o.in_peak      = out_peak_q;
  assign result_o.marker_event = out_event_q;

  // a beat that makes no slope test leaves the peak state alone
  a_no_test_no_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_adv && !s3_test_q) |=> ($stable(count_q) && $stable(peak_q) && $stable(edge_q)))
    else $error("peak state changed without a slope test");

  // the count moves only on a tested beat that leaves a peak
  a_count_only_on_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(s3_adv && s3_test_q && peak_q && edge_q && !beyond))
    else $error("marker count changed outside a peak exit");

  // a reported marker always comes with the peak flag cleared
  a_event_clears_peak : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_event_q != lmpc_pkg::EvNone)) |-> !out_peak_q)
    else $error("marker event reported while still in a peak");

endmodule
